// ----- rtl/sil_pkg.sv -----
package sil_pkg;

	localparam int DEPTH = 32;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = ((CNT_W > 6) ? CNT_W : 6) + 1;

	typedef logic signed [31:0] elem_t;

	typedef enum logic [2:0] {
		FN_SORTED = 3'd0,
		FN_HEAD   = 3'd1,
		FN_TAIL   = 3'd2,
		FN_BEFORE = 3'd3,
		FN_AFTER  = 3'd4,
		FN_READ   = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_BAD_INDEX = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_EMPTY     = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_READ = 1'b1
	} state_t;

	// Broadcast to every cell of the row.
	typedef struct packed {
		logic             load;
		logic             rotate;
		logic             sorted;
		elem_t            value;
		logic [CNT_W-1:0] pos;
		logic [CNT_W-1:0] cnt;
	} cell_ctl_t;

endpackage

// ----- rtl/sil_cell.sv -----
module sil_cell (
	input  logic                      clk,
	input  sil_pkg::cell_ctl_t        ctl,
	input  logic [sil_pkg::IDX_W-1:0] cell_num,
	input  logic                      prev_at,
	input  logic                      at_in,
	input  logic                      wrap,
	input  sil_pkg::elem_t            prev_data,
	input  sil_pkg::elem_t            next_data,
	input  sil_pkg::elem_t            head_data,
	output logic                      hit,
	output sil_pkg::elem_t            data
);

	sil_pkg::elem_t data_q;
	logic           valid;
	logic           less;

	assign valid = ctl.cnt > sil_pkg::CNT_W'(cell_num);
	assign less  = data_q < ctl.value;
	// A cell at or after the insertion point raises hit.
	assign hit   = ctl.sorted ? (!valid || !less)
	                          : (sil_pkg::CNT_W'(cell_num) >= ctl.pos);
	assign data  = data_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			if (prev_at) begin
				data_q <= prev_data;
			end else if (at_in) begin
				data_q <= ctl.value;
			end
		end else if (ctl.rotate) begin
			data_q <= wrap ? head_data : next_data;
		end
	end

endmodule

// ----- rtl/sorted_insertion_list.sv -----
// Sorted insertion list: an ordered list of up to DEPTH signed 32-bit values.
// Input channel: a command beat is taken at a rising edge where start is high
// and busy is low; func selects sorted insert, head, tail, before index,
// after index or readout, with value and index alongside.
// Result channel: strobe marks each result beat for exactly one cycle, with
// status, element, count and last. The receiver cannot stall, so no result is
// ever held back; it must take every beat as it appears.
// An insert, a rejected command or an unused code answers with one beat in
// the cycle after it is taken, and busy stays low, so commands of that kind
// may be issued on every cycle.
// A readout raises busy until its last element is out and takes no command
// meanwhile; an empty list answers with a single beat flagged empty. The state
// register enters the readout state, then the result registers take the
// elements one per cycle from cell zero as the row rotates, the final with last set.
// The storage is a row of identical cells. An insert loads the new value into
// the cell at the insertion point while every cell behind it takes its
// neighbour's value; a readout rotates the occupied cells past cell zero.
// Reset clears the element count and the handshake state; cell contents are
// not cleared, since only occupied cells are ever read.
module sorted_insertion_list (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  func,
	input  logic signed [31:0] value,
	input  logic [5:0]  index,
	output logic        strobe,
	output logic [1:0]  status,
	output logic signed [31:0] element,
	output logic [5:0]  count,
	output logic        last
);

	localparam int DEPTH = sil_pkg::DEPTH;
	localparam int CNT_W = sil_pkg::CNT_W;
	localparam int CMP_W = sil_pkg::CMP_W;

	sil_pkg::state_t           state_q, state_d;
	logic [CNT_W-1:0]          cnt_q, cnt_d;
	logic [CNT_W-1:0]          rem_q, rem_d;
	logic                      strobe_q, strobe_d;
	sil_pkg::status_t          status_q, status_d;
	sil_pkg::elem_t            element_q, element_d;
	logic [CNT_W-1:0]          cnt_out_q, cnt_out_d;
	logic                      last_q, last_d;

	sil_pkg::cell_ctl_t        ctl;
	sil_pkg::func_t            fn;
	logic                      accept;
	logic                      is_ins;
	logic                      bad_idx;
	logic                      full;
	logic [CMP_W-1:0]          idx_x;
	logic [CMP_W-1:0]          cnt_x;
	logic [CMP_W-1:0]          idx_p1;
	logic [CNT_W-1:0]          ins_pos;
	logic [DEPTH-1:0]          hit;
	logic [DEPTH-1:0]          low_hit;
	logic [DEPTH-1:0]          at_mask;
	sil_pkg::elem_t            cell_data [DEPTH];

	assign fn      = sil_pkg::func_t'(func);
	assign busy    = (state_q == sil_pkg::S_READ);
	assign accept  = start && !busy;
	assign idx_x   = CMP_W'(index);
	assign cnt_x   = CMP_W'(cnt_q);
	assign idx_p1  = idx_x + CMP_W'(1);
	assign is_ins  = (fn == sil_pkg::FN_SORTED) || (fn == sil_pkg::FN_HEAD)
	              || (fn == sil_pkg::FN_TAIL) || (fn == sil_pkg::FN_BEFORE)
	              || (fn == sil_pkg::FN_AFTER);
	assign bad_idx = ((fn == sil_pkg::FN_BEFORE) || (fn == sil_pkg::FN_AFTER))
	              && (idx_x > cnt_x);
	assign full    = (cnt_q == CNT_W'(DEPTH));

	// Insertion point for the positional commands; the sorted insert finds its
	// own point from the cell comparisons.
	always_comb begin
		ins_pos = cnt_q;
		case (fn)
			sil_pkg::FN_HEAD:   ins_pos = '0;
			sil_pkg::FN_TAIL:   ins_pos = cnt_q;
			sil_pkg::FN_BEFORE: ins_pos = index[CNT_W-1:0] & {CNT_W{1'b1}};
			sil_pkg::FN_AFTER:  ins_pos = (idx_p1 > cnt_x) ? cnt_q : idx_p1[CNT_W-1:0];
			default:            ins_pos = cnt_q;
		endcase
	end

	assign ctl.pos    = ins_pos;
	assign ctl.load   = accept && is_ins && !bad_idx && !full;
	assign ctl.rotate = busy;
	assign ctl.sorted = (fn == sil_pkg::FN_SORTED);
	assign ctl.value  = value;
	assign ctl.cnt    = cnt_q;

	// The first raised hit marks the insertion cell; every cell from there on
	// is at or after it. There is always at least one hit while the list is not full.
	assign low_hit = hit & (~hit + DEPTH'(1));
	assign at_mask = ~(low_hit - DEPTH'(1));

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		sil_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.cell_num  (sil_pkg::IDX_W'(k)),
			.prev_at   ((k == 0) ? 1'b0 : at_mask[(k == 0) ? 0 : k - 1]),
			.at_in     (at_mask[k]),
			.wrap      (cnt_q == CNT_W'(k + 1)),
			.prev_data (cell_data[(k == 0) ? 0 : k - 1]),
			.next_data (cell_data[(k == DEPTH - 1) ? 0 : k + 1]),
			.head_data (cell_data[0]),
			.hit       (hit[k]),
			.data      (cell_data[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sil_pkg::S_IDLE;
			cnt_q    <= '0;
			rem_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			rem_q    <= rem_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		status_q  <= status_d;
		element_q <= element_d;
		cnt_out_q <= cnt_out_d;
		last_q    <= last_d;
	end

	// Next state and the result register contents.
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		rem_d     = rem_q;
		strobe_d  = 1'b0;
		status_d  = sil_pkg::STAT_OK;
		element_d = '0;
		cnt_out_d = cnt_q;
		last_d    = 1'b1;
		case (state_q)
			sil_pkg::S_IDLE: begin
				if (accept) begin
					strobe_d = 1'b1;
					if (fn == sil_pkg::FN_READ) begin
						if (cnt_q == '0) begin
							status_d = sil_pkg::STAT_EMPTY;
						end else begin
							// The readout beats come from the rotation.
							strobe_d = 1'b0;
							rem_d    = cnt_q;
							state_d  = sil_pkg::S_READ;
						end
					end else if (is_ins) begin
						if (bad_idx) begin
							status_d = sil_pkg::STAT_BAD_INDEX;
						end else if (full) begin
							status_d = sil_pkg::STAT_FULL;
						end else begin
							cnt_d     = cnt_q + CNT_W'(1);
							cnt_out_d = cnt_q + CNT_W'(1);
						end
					end
				end
			end
			sil_pkg::S_READ: begin
				strobe_d  = 1'b1;
				element_d = cell_data[0];
				last_d    = (rem_q == CNT_W'(1));
				rem_d     = rem_q - CNT_W'(1);
				if (rem_q == CNT_W'(1)) begin
					state_d = sil_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sil_pkg::S_IDLE;
			end
		endcase
	end

	assign strobe  = strobe_q;
	assign status  = status_q;
	assign element = element_q;
	assign count   = 6'(cnt_out_q);
	assign last    = last_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("element count exceeds the list depth");

	a_read_cnt_stable: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> $stable(cnt_q))
		else $error("element count changed during a readout");

	a_read_continues: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !last_q |=> strobe_q)
		else $error("readout stream broke off before its last beat");

	a_empty_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && (status_q == sil_pkg::STAT_EMPTY) |-> last_q && (cnt_out_q == '0))
		else $error("empty readout beat malformed");

	a_read_rem: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (rem_q != '0) && (rem_q <= cnt_q))
		else $error("readout counter out of range");

endmodule

// ----- dv/sorted_insertion_list_tb.sv -----
`timescale 1ns / 100ps

module sorted_insertion_list_tb;
	import sil_pkg::*;

	// Function codes above the readout are unused by the block; it answers
	// them with a single plain beat and leaves the list alone.
	localparam logic [2:0] FN_SPARE6 = 3'd6;
	localparam logic [2:0] FN_SPARE7 = 3'd7;

	// Number of random commands after the directed opening.
	localparam int RANDOM_CMDS = 110;
	// With this few commands left the driver starts no further idle gaps.
	localparam int CALM_TAIL = 16;
	// Cycles allowed after the last expected beat for a stray one to show up.
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic [2:0] f;
		elem_t      v;
		logic [5:0] idx;
	} command_t;

	typedef struct {
		status_t    status;
		elem_t      element;
		logic [5:0] count;
		logic       last;
	} result_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  func = 3'd0;
	elem_t       value = '0;
	logic [5:0]  index = '0;
	logic        strobe;
	logic [1:0]  status;
	elem_t       element;
	logic [5:0]  count;
	logic        last;

	// Commands still to be issued, the beats the list must still produce,
	// and our own copy of the list contents.
	command_t     pending_cmds[$];
	result_beat_t awaited_beats[$];
	elem_t        list_copy[$];

	command_t cur_cmd;
	int       gen_count = 0;
	int       gap_left = 0;
	int       idle_pct = 20;
	int       cmds_taken = 0;
	int       errors = 0;

	sorted_insertion_list dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.func    (func),
		.value   (value),
		.index   (index),
		.strobe  (strobe),
		.status  (status),
		.element (element),
		.count   (count),
		.last    (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void await_beat(status_t s, elem_t e, int n, logic l);
		result_beat_t b;
		b.status = s;
		b.element = e;
		b.count = n[5:0];
		b.last = l;
		awaited_beats.push_back(b);
	endfunction

	// Works out the beats one accepted command must produce and updates our
	// copy of the list. The index check is made before the full check, so a
	// bad index on a full list still reports the index.
	function automatic void predict_list_beats(command_t c);
		int n;
		int pos;
		n = list_copy.size();
		pos = n;
		if (c.f == FN_READ) begin
			if (n == 0) begin
				await_beat(STAT_EMPTY, '0, 0, 1'b1);
			end else begin
				for (int k = 0; k < n; k++)
					await_beat(STAT_OK, list_copy[k], n, k == n - 1);
			end
		end else if (c.f > FN_READ) begin
			await_beat(STAT_OK, '0, n, 1'b1);
		end else if ((c.f == FN_BEFORE || c.f == FN_AFTER) && c.idx > n) begin
			await_beat(STAT_BAD_INDEX, '0, n, 1'b1);
		end else if (n >= DEPTH) begin
			await_beat(STAT_FULL, '0, n, 1'b1);
		end else begin
			case (c.f)
				FN_SORTED: begin
					// The new value goes in front of the first element that
					// is not smaller, so equal values land ahead of old ones.
					for (int k = 0; k < n; k++) begin
						if (!(list_copy[k] < c.v)) begin
							pos = k;
							break;
						end
					end
				end
				FN_HEAD:   pos = 0;
				FN_TAIL:   pos = n;
				FN_BEFORE: pos = c.idx;
				default: begin
					// After the last element means a new tail.
					pos = (c.idx + 1 > n) ? n : c.idx + 1;
				end
			endcase
			list_copy.insert(pos, c.v);
			await_beat(STAT_OK, '0, n + 1, 1'b1);
		end
	endfunction

	// Queues one command and keeps a running count of how full the list will
	// be, so that the stimulus can aim indexes at valid and invalid places.
	function automatic void add_cmd(logic [2:0] f, elem_t v, int idx);
		command_t c;
		c.f = f;
		c.v = v;
		c.idx = idx[5:0];
		pending_cmds.push_back(c);
		if (f <= FN_AFTER && gen_count < DEPTH &&
				!((f == FN_BEFORE || f == FN_AFTER) && idx > gen_count))
			gen_count++;
	endfunction

	// Values are a mix of the extremes, a narrow band that makes ties and
	// near neighbours common, and the full 32-bit range.
	function automatic elem_t pick_value();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 25) begin
			case ($urandom_range(0, 4))
				0: return 32'sh8000_0000;
				1: return 32'sh7FFF_FFFF;
				2: return 32'sh0;
				3: return -32'sd1;
				default: return 32'sd1;
			endcase
		end else if (sel < 50) begin
			return $signed($urandom_range(0, 16)) - 32'sd8;
		end
		return $urandom;
	endfunction

	// Driver. A beat is taken at an edge where start is high and busy is low;
	// at that edge the command on the ports goes into the predictor and the
	// next one is presented. While the list is busy with a readout the
	// command is simply held. Idle bursts are drawn per command, with the
	// idling rate itself changing every twenty commands so that some
	// stretches run with no gaps at all.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				predict_list_beats(cur_cmd);
				cmds_taken++;
				if (cmds_taken % 20 == 0) begin
					case ($urandom_range(0, 2))
						0: idle_pct = 0;
						1: idle_pct = 15;
						default: idle_pct = 45;
					endcase
				end
			end
			if (!start || !busy) begin
				if (gap_left != 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_cmds.size() == 0) begin
					start <= 1'b0;
				end else if (pending_cmds.size() > CALM_TAIL &&
						$urandom_range(0, 99) < idle_pct) begin
					gap_left = $urandom_range(0, 8);
					start <= 1'b0;
				end else begin
					cur_cmd = pending_cmds.pop_front();
					start <= 1'b1;
					func <= cur_cmd.f;
					value <= cur_cmd.v;
					index <= cur_cmd.idx;
				end
			end
		end
	end

	task automatic report_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Monitor. The receiver cannot stall, so every strobed cycle is one beat
	// and is checked against the oldest beat still awaited.
	always @(posedge clk) begin
		result_beat_t want;
		if (arst_n && strobe) begin
			if (awaited_beats.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual status %0d element %0d",
					$time, status, element);
				errors++;
			end else begin
				want = awaited_beats.pop_front();
				if ({status, element, count, last} !==
						{want.status, want.element, want.count, want.last}) begin
					report_field("status", want.status, status);
					report_field("element", want.element, element);
					report_field("count", want.count, count);
					report_field("last", want.last, last);
					if ($isunknown({status, element, count, last})) begin
						$display("%0t: unknown bits on result beat, expected known, actual %b",
							$time, {status, element, count, last});
						errors++;
					end
				end
			end
		end
	end

	initial begin
		int sel;
		logic [2:0] f;

		// Directed opening: a readout of the empty list, the unused codes and bad indexes,
		// then the sorted extremes and a tie, then each positional insert at its boundary cases.
		add_cmd(FN_READ, pick_value(), 0);
		add_cmd(FN_SPARE6, 32'sh7FFF_FFFF, 63);
		add_cmd(FN_SPARE7, 32'sh8000_0000, 0);
		add_cmd(FN_BEFORE, 32'sd3, 1);
		add_cmd(FN_AFTER, 32'sd3, 63);
		// After index zero on an empty list becomes the only element.
		add_cmd(FN_AFTER, 32'sd5, 0);
		add_cmd(FN_SORTED, 32'sd0, 0);
		add_cmd(FN_SORTED, 32'sh7FFF_FFFF, 0);
		add_cmd(FN_SORTED, 32'sh8000_0000, 0);
		add_cmd(FN_SORTED, -32'sd1, 0);
		add_cmd(FN_SORTED, 32'sd0, 0);
		add_cmd(FN_HEAD, 32'sd42, 0);
		add_cmd(FN_TAIL, -32'sd42, 0);
		add_cmd(FN_BEFORE, 32'sd100, 0);
		add_cmd(FN_BEFORE, 32'sd101, gen_count);
		add_cmd(FN_AFTER, 32'sd102, gen_count - 1);
		add_cmd(FN_AFTER, 32'sd103, gen_count);
		add_cmd(FN_AFTER, 32'sd104, 3);
		add_cmd(FN_BEFORE, 32'sd105, 5);
		add_cmd(FN_BEFORE, 32'sd106, gen_count + 1);
		add_cmd(FN_READ, pick_value(), 63);

		// Random part. Inserts dominate so that the list reaches full within
		// the run, after which rejections and full readouts take over.
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 40) begin
				add_cmd(FN_SORTED, pick_value(), $urandom_range(0, 63));
			end else if (sel < 48) begin
				add_cmd(FN_HEAD, pick_value(), $urandom_range(0, 63));
			end else if (sel < 56) begin
				add_cmd(FN_TAIL, pick_value(), $urandom_range(0, 63));
			end else if (sel < 68) begin
				add_cmd(FN_BEFORE, pick_value(), $urandom_range(0, gen_count));
			end else if (sel < 80) begin
				add_cmd(FN_AFTER, pick_value(), $urandom_range(0, gen_count));
			end else if (sel < 90) begin
				add_cmd(FN_READ, pick_value(), $urandom_range(0, 63));
			end else if (sel < 96) begin
				f = ($urandom_range(0, 1) != 0) ? FN_BEFORE : FN_AFTER;
				add_cmd(f, pick_value(), $urandom_range(gen_count + 1, 63));
			end else begin
				f = ($urandom_range(0, 1) != 0) ? FN_SPARE7 : FN_SPARE6;
				add_cmd(f, pick_value(), $urandom_range(0, 63));
			end
		end
		add_cmd(FN_READ, pick_value(), 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || start)
			@(posedge clk);
		while (awaited_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("PASS sorted_insertion_list");
		end else begin
			$display("FAIL sorted_insertion_list");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest correct run of this stimulus.
	initial begin
		#1000000;
		$display("FAIL sorted_insertion_list");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/sil_pkg.sv
rtl/sil_cell.sv
rtl/sorted_insertion_list.sv
dv/sorted_insertion_list_tb.sv
